FILE: rtl/core/envelope_memory_polynomial_eval_defines.svh
// Assertion macros for the envelope memory polynomial evaluator.
`ifndef ENVELOPE_MEMORY_POLYNOMIAL_EVAL_DEFINES_SVH
`define ENVELOPE_MEMORY_POLYNOMIAL_EVAL_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define EMP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that a condition implies a consequence in the cycle after it.
`define EMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/emp_pkg.sv
// -----------------------------------------------------------------------------
// emp_pkg
// Types and constants of the envelope memory polynomial evaluator.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
package emp_pkg;
  localparam int unsigned CoefW   = 18;
  localparam int unsigned SampW   = 16;
  localparam int unsigned MagW    = 17;
  localparam int unsigned PowW    = 23;
  localparam int unsigned OutW    = 24;
  localparam int unsigned TabAw   = 6;
  localparam int unsigned TabSize = 64;
  localparam int unsigned AccW    = 48;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpSample = 1'b1;

  localparam logic [1:0] RegDepth = 2'd0;
  localparam logic [1:0] RegOrder = 2'd1;

  typedef enum logic [3:0] {
    StIdle, StSqrt, StHist, StMac, StMacW, StRound, StOutM, StOutR, StDone
  } state_e;
endpackage

FILE: rtl/core/envelope_memory_polynomial_eval.sv
// -----------------------------------------------------------------------------
// envelope_memory_polynomial_eval
// Envelope memory polynomial on a complex sample stream, fixed point.
// -----------------------------------------------------------------------------
// A coefficient load writes the table and leaves the block idle. A sample
// first runs the bit-serial magnitude root (one result bit per cycle), then
// writes the history; a sample still in warm-up ends there. Then each table
// term goes through the single complex multiply-accumulate (table read, then
// accumulate while the next power is formed), and then come rounding, the
// final complex multiply, and its rounding and saturation into the result.
// Results wait in an output register, which holds off the next input.
`timescale 1ns / 1ps
module envelope_memory_polynomial_eval #(
  parameter int unsigned MAX_ORDER = 8,
  parameter int unsigned MAX_DEPTH = 7
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic opcode_i,
  input  logic [5:0] coef_index_i,
  input  logic signed [17:0] coef_re_i,
  input  logic signed [17:0] coef_im_i,
  input  logic signed [15:0] sample_re_i,
  input  logic signed [15:0] sample_im_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic signed [23:0] out_re_o,
  output logic signed [23:0] out_im_o,
  output logic saturated_o,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_data_i
);
  import emp_pkg::*;

  localparam int unsigned HistSize = MAX_DEPTH + 1;
  localparam int unsigned HAw = (HistSize > 1) ? $clog2(HistSize) : 1;
  localparam int unsigned KW = $clog2(MAX_ORDER + 1);
  localparam int unsigned DW = $clog2(MAX_DEPTH + 1) + 1;

  logic [35:0] tab_mem [TabSize];
  logic [35:0] tab_rd_q;
  logic [MagW-1:0] hist_mem [HistSize];
  logic [MagW-1:0] hist_rd_q;
  logic [HistSize-1:0] hist_vld_q;
  logic hist_rd_vld_q;

  state_e state_q, state_d;
  logic [2:0] depth_q;
  logic [3:0] order_q;
  logic [HAw-1:0] wp_q, hp_q;
  logic [3:0] seen_q;
  logic signed [SampW-1:0] xr_q, xi_q;
  logic [31:0] rem_q, root_q;
  logic [4:0] bit_q;
  logic [KW-1:0] kk_q, kcnt_q;
  logic [DW-1:0] mm_q, mcnt_q;
  logic [6:0] slot_q;
  logic [PowW-1:0] pow_q;
  logic signed [AccW-1:0] sr_q, si_q;
  logic signed [40:0] s15r_q, s15i_q;
  logic signed [63:0] pr1_q, pr2_q, pi1_q, pi2_q;
  logic signed [OutW-1:0] ore_q, oim_q;
  logic osat_q, ovld_q;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign in_ready_o = (state_q == StIdle) && !ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= 3'd5;
      order_q <= 4'd5;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegDepth) depth_q <= cfg_data_i[2:0];
      else if (cfg_index_i == RegOrder) order_q <= cfg_data_i;
    end
  end

  // root step
  logic [31:0] trial;
  logic [31:0] bitv;
  assign bitv = 32'd1 << {bit_q, 1'b0};
  assign trial = root_q + bitv;

  always_ff @(posedge clk_i) begin
    if (in_acc && opcode_i == OpLoad)
      tab_mem[coef_index_i] <= {coef_re_i, coef_im_i};
    tab_rd_q <= tab_mem[slot_q[TabAw-1:0]];
    if (state_q == StHist) hist_mem[wp_q] <= root_q[MagW-1:0];
    hist_rd_q <= hist_mem[hp_q];
  end

  logic [MagW-1:0] mag;
  assign mag = hist_rd_vld_q ? hist_rd_q : '0;
  logic signed [17:0] cre, cim;
  assign cre = tab_rd_q[35:18];
  assign cim = tab_rd_q[17:0];
  logic [PowW+MagW-1:0] pprod;
  assign pprod = pow_q * mag + (PowW+MagW)'(16384);
  logic signed [63:0] yr_w, yi_w;
  assign yr_w = (pr1_q - pr2_q + 64'sd16384) >>> 15;
  assign yi_w = (pi1_q + pi2_q + 64'sd16384) >>> 15;
  logic signed [AccW-1:0] sr_n, si_n;
  assign sr_n = sr_q + AccW'(cre * $signed({1'b0, pow_q}));
  assign si_n = si_q + AccW'(cim * $signed({1'b0, pow_q}));
  logic slot_ok;
  assign slot_ok = slot_q < 7'(TabSize);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc && opcode_i == OpSample) state_d = StSqrt;
      StSqrt:  if (bit_q == 5'd0) state_d = StHist;
      StHist:  state_d = (seen_q < 4'(mm_q)) ? StIdle : StMac;
      StMac:   state_d = StMacW;
      StMacW:  state_d = (kcnt_q == kk_q - 1'b1 && mcnt_q == mm_q) ? StRound : StMac;
      StRound: state_d = StOutM;
      StOutM:  state_d = StOutR;
      StOutR:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wp_q <= '0;
      seen_q <= '0;
      hist_vld_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_acc) ovld_q <= 1'b0;
      if (state_q == StHist) begin
        hist_vld_q[wp_q] <= 1'b1;
        wp_q <= (32'(wp_q) + 1 >= HistSize) ? '0 : wp_q + 1'b1;
        if (seen_q != 4'd15) seen_q <= seen_q + 1'b1;
      end
      if (state_q == StOutR) ovld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    hist_rd_vld_q <= hist_vld_q[hp_q];
    unique case (state_q)
      StIdle: begin
        xr_q <= sample_re_i;
        xi_q <= sample_im_i;
        rem_q <= 32'(sample_re_i * sample_re_i) + 32'(sample_im_i * sample_im_i);
        root_q <= '0;
        bit_q <= 5'd15;
        kk_q <= (order_q == 4'd0) ? KW'(1) :
                (32'(order_q) > MAX_ORDER) ? KW'(MAX_ORDER) : KW'(order_q);
        mm_q <= (32'(depth_q) > MAX_DEPTH) ? DW'(MAX_DEPTH) : DW'(depth_q);
      end
      StSqrt: begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          root_q <= (root_q >> 1) + bitv;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q - 1'b1;
      end
      StHist: begin
        hp_q <= wp_q;
        kcnt_q <= '0;
        mcnt_q <= '0;
        slot_q <= '0;
        pow_q <= PowW'(32768);
        sr_q <= '0;
        si_q <= '0;
      end
      StMac: ;
      StMacW: begin
        if (slot_ok) begin
          sr_q <= sr_n;
          si_q <= si_n;
        end
        slot_q <= slot_q + 1'b1;
        if (kcnt_q == kk_q - 1'b1) begin
          kcnt_q <= '0;
          mcnt_q <= mcnt_q + 1'b1;
          pow_q <= PowW'(32768);
          hp_q <= (hp_q == '0) ? HAw'(HistSize - 1) : hp_q - 1'b1;
        end else begin
          kcnt_q <= kcnt_q + 1'b1;
          pow_q <= PowW'(pprod >> 15);
        end
      end
      StRound: begin
        s15r_q <= 41'((sr_q + AccW'(8192)) >>> 14);
        s15i_q <= 41'((si_q + AccW'(8192)) >>> 14);
      end
      StOutM: begin
        pr1_q <= 64'(xr_q * s15r_q);
        pr2_q <= 64'(xi_q * s15i_q);
        pi1_q <= 64'(xr_q * s15i_q);
        pi2_q <= 64'(xi_q * s15r_q);
      end
      StOutR: begin
        osat_q <= 1'b0;
        if (yr_w > 64'sd8388607) begin ore_q <= 24'sh7fffff; osat_q <= 1'b1; end
        else if (yr_w < -64'sd8388608) begin ore_q <= 24'sh800000; osat_q <= 1'b1; end
        else ore_q <= yr_w[23:0];
        if (yi_w > 64'sd8388607) begin oim_q <= 24'sh7fffff; osat_q <= 1'b1; end
        else if (yi_w < -64'sd8388608) begin oim_q <= 24'sh800000; osat_q <= 1'b1; end
        else oim_q <= yi_w[23:0];
      end
      default: ;
    endcase
  end

  assign out_valid_o = ovld_q;
  assign out_re_o = ore_q;
  assign out_im_o = oim_q;
  assign saturated_o = osat_q;
endmodule

FILE: rtl/core/emp_checker.sv
// -----------------------------------------------------------------------------
// emp_checker
// Port checks of the envelope memory polynomial evaluator.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "envelope_memory_polynomial_eval_defines.svh"
module emp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic signed [23:0] out_re_o
);
  `EMP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `EMP_ASSERT_NEXT(a_re_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_re_o))
  `EMP_ASSERT_IMP(a_no_take_full, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `EMP_ASSERT_NEXT(a_busy_after, clk_i, rst_ni, in_valid_i && in_ready_o, !out_valid_o)
endmodule

bind envelope_memory_polynomial_eval emp_checker u_emp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_re_o(out_re_o)
);
